[hdl/i2cms_pkg.sv]
// ----------------------------------------------------------------------------
// i2cms_pkg
// shared types and constants of the i2c master transaction sequencer
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  typedef enum logic [2:0] {
    CMD_LOAD       = 3'd0,
    CMD_START_WR   = 3'd1,
    CMD_START_RD   = 3'd2,
    CMD_START_WRRD = 3'd3,
    CMD_DONE       = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WRITE = 2'd1,
    PH_READ  = 2'd2
  } phase_t;

  typedef struct packed {
    logic             we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic       issue_start;
    logic       issue_restart;
    logic       issue_stop;
    logic       transmit_dir;
    logic       send_valid;
    logic [7:0] send_value;
    logic       send_from_mem;
    logic       nack_next;
    logic       got_valid;
    logic [7:0] got_value;
    logic [7:0] got_position;
    logic       busy;
    logic       write_failed;
  } res_t;

endpackage

[hdl/i2cms_tx_ram.sv]
// ----------------------------------------------------------------------------
// i2cms_tx_ram
// transmit byte buffer, one write port and one registered read port
// ----------------------------------------------------------------------------
module i2cms_tx_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/i2cms_ctrl.sv]
// ----------------------------------------------------------------------------
// i2cms_ctrl
// transaction state and per-transaction decision, buffer access requests
// ----------------------------------------------------------------------------
module i2cms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [2:0]          cmd,
  input  logic [6:0]          target_address,
  input  logic [7:0]          write_length,
  input  logic [7:0]          read_length,
  input  logic [7:0]          load_index,
  input  logic [7:0]          load_value,
  input  logic                ack_seen,
  input  logic [7:0]          bus_byte,
  output i2cms_pkg::mem_req_t mem_req,
  output i2cms_pkg::res_t     res
);

  i2cms_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic       pending_r, pending_nxt;
  logic [6:0] saved_addr_r, saved_addr_nxt;
  logic [7:0] saved_rlen_r, saved_rlen_nxt;
  logic       first_r, first_nxt;
  logic [7:0] send_ptr_r, send_ptr_nxt;
  logic [7:0] recv_ptr_r, recv_ptr_nxt;
  logic       err_r, err_nxt;
  logic [i2cms_pkg::ADDR_W-1:0] ptr_mod;
  logic       load_ok;
  logic       we, re;

  assign ptr_mod = i2cms_pkg::ADDR_W'({1'b0, send_ptr_r} % 9'(i2cms_pkg::BUFFER_DEPTH));
  assign load_ok = ({1'b0, load_index} < 9'(i2cms_pkg::BUFFER_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= i2cms_pkg::PH_IDLE;
      bytes_left_r <= 8'd0;
      pending_r    <= 1'b0;
      saved_addr_r <= 7'd0;
      saved_rlen_r <= 8'd0;
      first_r      <= 1'b1;
      send_ptr_r   <= 8'd0;
      recv_ptr_r   <= 8'd0;
      err_r        <= 1'b0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      pending_r    <= pending_nxt;
      saved_addr_r <= saved_addr_nxt;
      saved_rlen_r <= saved_rlen_nxt;
      first_r      <= first_nxt;
      send_ptr_r   <= send_ptr_nxt;
      recv_ptr_r   <= recv_ptr_nxt;
      err_r        <= err_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    pending_nxt    = pending_r;
    saved_addr_nxt = saved_addr_r;
    saved_rlen_nxt = saved_rlen_r;
    first_nxt      = first_r;
    send_ptr_nxt   = send_ptr_r;
    recv_ptr_nxt   = recv_ptr_r;
    err_nxt        = err_r;
    we             = 1'b0;
    re             = 1'b0;
    res            = '0;

    case (cmd)
      i2cms_pkg::CMD_LOAD: begin
        we = load_ok;
      end
      i2cms_pkg::CMD_START_WR, i2cms_pkg::CMD_START_WRRD: begin
        saved_addr_nxt  = target_address;
        phase_nxt       = i2cms_pkg::PH_WRITE;
        bytes_left_nxt  = write_length;
        send_ptr_nxt    = 8'd0;
        recv_ptr_nxt    = 8'd0;
        first_nxt       = 1'b1;
        err_nxt         = 1'b0;
        pending_nxt     = (cmd == i2cms_pkg::CMD_START_WRRD);
        saved_rlen_nxt  = (cmd == i2cms_pkg::CMD_START_WRRD) ? read_length : 8'd0;
        res.issue_start = 1'b1;
        res.send_valid  = 1'b1;
        res.send_value  = {target_address, 1'b0};
      end
      i2cms_pkg::CMD_START_RD: begin
        saved_addr_nxt  = target_address;
        phase_nxt       = i2cms_pkg::PH_READ;
        bytes_left_nxt  = read_length;
        send_ptr_nxt    = 8'd0;
        recv_ptr_nxt    = 8'd0;
        first_nxt       = 1'b1;
        err_nxt         = 1'b0;
        pending_nxt     = 1'b0;
        res.issue_start = 1'b1;
        res.send_valid  = 1'b1;
        res.send_value  = {target_address, 1'b1};
      end
      i2cms_pkg::CMD_DONE: begin
        case (phase_r)
          i2cms_pkg::PH_WRITE: begin
            if (bytes_left_r == 8'd0) begin
              if (pending_r) begin
                phase_nxt         = i2cms_pkg::PH_READ;
                bytes_left_nxt    = saved_rlen_r;
                pending_nxt       = 1'b0;
                first_nxt         = 1'b1;
                recv_ptr_nxt      = 8'd0;
                res.issue_restart = 1'b1;
                res.send_valid    = 1'b1;
                res.send_value    = {saved_addr_r, 1'b1};
              end else begin
                phase_nxt      = i2cms_pkg::PH_IDLE;
                res.issue_stop = 1'b1;
              end
            end else if (ack_seen) begin
              re                = 1'b1;
              res.send_valid    = 1'b1;
              res.send_from_mem = 1'b1;
              send_ptr_nxt      = 8'(send_ptr_r + 8'd1);
              bytes_left_nxt    = 8'(bytes_left_r - 8'd1);
            end else begin
              err_nxt        = 1'b1;
              pending_nxt    = 1'b0;
              phase_nxt      = i2cms_pkg::PH_IDLE;
              res.issue_stop = 1'b1;
            end
          end
          i2cms_pkg::PH_READ: begin
            if (bytes_left_r == 8'd0) begin
              phase_nxt      = i2cms_pkg::PH_IDLE;
              res.issue_stop = 1'b1;
            end else begin
              res.nack_next  = (bytes_left_r == 8'd1);
              bytes_left_nxt = 8'(bytes_left_r - 8'd1);
            end
            if (!first_r) begin
              res.got_valid    = 1'b1;
              res.got_value    = bus_byte;
              res.got_position = recv_ptr_r;
              recv_ptr_nxt     = 8'(recv_ptr_r + 8'd1);
            end
            first_nxt = 1'b0;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    res.transmit_dir = (phase_nxt == i2cms_pkg::PH_WRITE) ||
                       ((phase_nxt == i2cms_pkg::PH_READ) && first_nxt);
    res.busy         = (phase_nxt == i2cms_pkg::PH_WRITE) ||
                       (phase_nxt == i2cms_pkg::PH_READ);
    res.write_failed = err_nxt;
  end

  assign mem_req.we    = fire && we;
  assign mem_req.waddr = load_index[i2cms_pkg::ADDR_W-1:0];
  assign mem_req.wdata = load_value;
  assign mem_req.re    = fire && re;
  assign mem_req.raddr = ptr_mod;

endmodule

[hdl/i2c_master_transaction_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_unit
// i2c master write, read and write-then-repeated-start-read sequencer
// ----------------------------------------------------------------------------
// Takes one transaction per clock cycle while in_ready is high and gives one
// result for each. A result passes the middle stage, with the synchronous
// transmit buffer read, then the output register. The control state updates
// at acceptance, so transactions follow back to back; while the output is
// stalled, one more transaction is taken and held in the middle stage. The
// transmit buffer has no reset and needs no clearing pass; the user must
// ensure a byte was loaded before it is sent, which the block does not check.
module i2c_master_transaction_sequencer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_cmd,
  input  logic [6:0] in_target_address,
  input  logic [7:0] in_write_length,
  input  logic [7:0] in_read_length,
  input  logic [7:0] in_load_index,
  input  logic [7:0] in_load_value,
  input  logic       in_ack_seen,
  input  logic [7:0] in_bus_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_issue_start,
  output logic       out_issue_restart,
  output logic       out_issue_stop,
  output logic       out_transmit_dir,
  output logic       out_send_valid,
  output logic [7:0] out_send_value,
  output logic       out_nack_next,
  output logic       out_got_valid,
  output logic [7:0] out_got_value,
  output logic [7:0] out_got_position,
  output logic       out_busy_res,
  output logic       out_write_failed
);

  i2cms_pkg::mem_req_t mem_req;
  i2cms_pkg::res_t     res;
  i2cms_pkg::res_t     s1_res_r;
  i2cms_pkg::res_t     s1_fwd;
  i2cms_pkg::res_t     o_res_r;
  logic                s1_valid_r;
  logic                o_valid_r;
  logic                in_fire;
  logic                advance;
  logic [7:0]          rdata;

  assign advance  = s1_valid_r && (!o_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  i2cms_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (in_fire),
    .cmd            (in_cmd),
    .target_address (in_target_address),
    .write_length   (in_write_length),
    .read_length    (in_read_length),
    .load_index     (in_load_index),
    .load_value     (in_load_value),
    .ack_seen       (in_ack_seen),
    .bus_byte       (in_bus_byte),
    .mem_req        (mem_req),
    .res            (res)
  );

  i2cms_tx_ram #(
    .DEPTH (i2cms_pkg::BUFFER_DEPTH),
    .WIDTH (8)
  ) u_tx_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        o_valid_r <= 1'b1;
      end else if (out_ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  // buffer byte joins the middle stage result
  always_comb begin
    s1_fwd = s1_res_r;
    if (s1_res_r.send_from_mem) begin
      s1_fwd.send_value = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_res_r <= res;
    end
    if (advance) begin
      o_res_r <= s1_fwd;
    end
  end

  assign out_valid         = o_valid_r;
  assign out_issue_start   = o_res_r.issue_start;
  assign out_issue_restart = o_res_r.issue_restart;
  assign out_issue_stop    = o_res_r.issue_stop;
  assign out_transmit_dir  = o_res_r.transmit_dir;
  assign out_send_valid    = o_res_r.send_valid;
  assign out_send_value    = o_res_r.send_value;
  assign out_nack_next     = o_res_r.nack_next;
  assign out_got_valid     = o_res_r.got_valid;
  assign out_got_value     = o_res_r.got_value;
  assign out_got_position  = o_res_r.got_position;
  assign out_busy_res      = o_res_r.busy;
  assign out_write_failed  = o_res_r.write_failed;

endmodule

[hdl/i2cms_checker.sv]
// ----------------------------------------------------------------------------
// i2cms_checker
// port-level checks of the sequencer, bound to the top level
// ----------------------------------------------------------------------------
module i2cms_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_issue_start,
  input logic       out_issue_restart,
  input logic       out_issue_stop,
  input logic       out_transmit_dir,
  input logic       out_send_valid,
  input logic [7:0] out_send_value,
  input logic       out_got_valid,
  input logic       out_busy_res,
  input logic       out_write_failed
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_send_value))
    else $error("stalled result changed");

  // start sends the write or read address, takes the bus, clears the error
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_issue_start |->
      out_send_valid && out_busy_res && out_transmit_dir && !out_write_failed)
    else $error("start transaction inconsistent");

  // repeated start sends a read address and keeps the bus
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_issue_restart |->
      out_send_valid && out_send_value[0] && out_busy_res && !out_issue_stop)
    else $error("repeated start inconsistent");

  // stop releases the bus and sends nothing
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_issue_stop |-> !out_busy_res && !out_send_valid && !out_transmit_dir)
    else $error("stop transaction inconsistent");

  // a received byte only shows in receive direction
  a_got: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_got_valid |-> !out_transmit_dir && !out_send_valid)
    else $error("received byte in transmit direction");

endmodule

bind i2c_master_transaction_sequencer_unit i2cms_checker u_i2cms_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_issue_start   (out_issue_start),
  .out_issue_restart (out_issue_restart),
  .out_issue_stop    (out_issue_stop),
  .out_transmit_dir  (out_transmit_dir),
  .out_send_valid    (out_send_valid),
  .out_send_value    (out_send_value),
  .out_got_valid     (out_got_valid),
  .out_busy_res      (out_busy_res),
  .out_write_failed  (out_write_failed)
);
